>>> sv/rlim_pkg.sv
// ----------------------------------------------------------------------------
// rlim_pkg
// Types and constants for the per-key fixed-window rate limiter.
// ----------------------------------------------------------------------------
package rlim_pkg;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int CNT_W16 = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_RST = 16'd60;
  localparam logic [CFG_DATA_W-1:0] MAX_RST    = 16'd60;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVER = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int          HASH_SHIFT = 5;
  localparam int          HASH_STEPS = 4;

  // remainder of the hash is built MOD_BITS bits per step, over MOD_STEPS steps
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = 32 / MOD_BITS;
  localparam int STEP_W    = 3;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic       limited;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  start;
    logic [CNT_W16-1:0] count;
  } entry_t;

endpackage

>>> sv/per_key_fixed_window_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// per_key_fixed_window_rate_limiter_core
// Per-key request counter over fixed time windows, table in one sync memory.
// ----------------------------------------------------------------------------
// A check hashes the key in HASH_STEPS steps and reduces the hash modulo
// TABLE_DEPTH in MOD_STEPS steps, then makes a probe pass of the table and,
// when no slot is free, an expiry scan, then updates the entry and presents the result.
// A clear writes every entry of the table. One item at a time; the single memory
// port sets the pace. After reset a clearing pass runs with in_stall high;
// configuration writes are taken at any time.
module per_key_fixed_window_rate_limiter_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rlim_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rlim_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlim_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlim_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rlim_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLR   = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_PROBE = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_UPD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] win_r, win_nxt;
  logic [CFG_DATA_W-1:0] max_r, max_nxt;

  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [31:0]        hsh_r, hsh_nxt;
  logic [KEY_W-1:0]   kshf_r, kshf_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [AW-1:0]      rem_r, rem_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pidx_r, pidx_nxt;
  logic               free_r, free_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [TIME_W-1:0]  ent_start_r, ent_start_nxt;
  logic [CNT_W16-1:0] ent_cnt_r, ent_cnt_nxt;
  logic               clr_res_r, clr_res_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  entry_t             tbl_mem [TABLE_DEPTH];
  entry_t             rd_data_r;
  logic               mem_re;
  logic [AW-1:0]      mem_ra;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  entry_t             mem_wd;

  logic [AW-1:0]      addr_inc;
  logic               addr_last;
  logic               pass_done;
  logic [AW:0]        md_t;
  logic [AW-1:0]      md_r;
  logic [31:0]        md_h;
  logic [TIME_W-1:0]  rd_age;
  logic [TIME_W-1:0]  upd_age;
  logic               upd_exp;
  logic [TIME_W-1:0]  upd_start;
  logic [CNT_W16-1:0] upd_cnt;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign addr_last = (addr_r == AW'(TABLE_DEPTH - 1));
  assign addr_inc  = addr_last ? '0 : addr_r + 1'b1;
  assign pass_done = (cnt_r == CW'(TABLE_DEPTH)) && !pend_r;
  assign rd_age    = now_r - rd_data_r.start;
  assign upd_age   = now_r - ent_start_r;
  assign upd_exp   = (upd_age >= TIME_W'(win_r));
  assign upd_start = upd_exp ? now_r : ent_start_r;
  assign upd_cnt   = upd_exp ? '0 : ent_cnt_r;

  always_comb begin
    md_r = rem_r;
    md_h = hsh_r;
    md_t = '0;
    for (int j = 0; j < MOD_BITS; j++) begin
      md_t = {md_r, md_h[31]};
      md_h = {md_h[30:0], 1'b0};
      if (md_t >= (AW+1)'(TABLE_DEPTH)) begin
        md_t = md_t - (AW+1)'(TABLE_DEPTH);
      end
      md_r = md_t[AW-1:0];
    end
  end

  always_comb begin
    win_nxt = win_r;
    max_nxt = max_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW: win_nxt = cfg_wdata;
        CFG_MAX:    max_nxt = cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    hsh_nxt       = hsh_r;
    kshf_nxt      = kshf_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    slot_nxt      = slot_r;
    ent_start_nxt = ent_start_r;
    ent_cnt_nxt   = ent_cnt_r;
    clr_res_nxt   = clr_res_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_re        = 1'b0;
    mem_ra        = addr_r;
    mem_we        = 1'b0;
    mem_wa        = addr_r;
    mem_wd        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.key;
          now_nxt = in_data.now_time;
          if (in_data.func == FUNC_CLEAR) begin
            clr_res_nxt = 1'b1;
            addr_nxt    = '0;
            state_nxt   = S_CLR;
          end else begin
            hsh_nxt   = HASH_SEED;
            kshf_nxt  = in_data.key;
            step_nxt  = '0;
            state_nxt = S_HASH;
          end
        end
      end
      S_CLR: begin
        mem_we   = 1'b1;
        mem_wa   = addr_r;
        addr_nxt = addr_inc;
        if (addr_last) begin
          if (clr_res_r) begin
            res_nxt   = '{limited: 1'b0, status: ST_OK};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_HASH: begin
        hsh_nxt  = ((hsh_r << HASH_SHIFT) + hsh_r) ^ {24'd0, kshf_r[31:24]};
        kshf_nxt = {kshf_r[23:0], 8'd0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(HASH_STEPS - 1)) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        hsh_nxt  = md_h;
        rem_nxt  = md_r;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(MOD_STEPS - 1)) begin
          addr_nxt  = md_r;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (cnt_r != CW'(TABLE_DEPTH)) begin
          mem_re   = 1'b1;
          mem_ra   = addr_r;
          pend_nxt = 1'b1;
          pidx_nxt = addr_r;
          addr_nxt = addr_inc;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (!rd_data_r.valid) begin
            if (!free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = pidx_r;
            end
          end else if (rd_data_r.key == key_r) begin
            slot_nxt      = pidx_r;
            ent_start_nxt = rd_data_r.start;
            ent_cnt_nxt   = rd_data_r.count;
            pend_nxt      = 1'b0;
            state_nxt     = S_UPD;
          end
        end
        if (pass_done) begin
          if (free_r) begin
            slot_nxt      = free_idx_r;
            ent_start_nxt = now_r;
            ent_cnt_nxt   = '0;
            state_nxt     = S_UPD;
          end else begin
            addr_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r != CW'(TABLE_DEPTH)) begin
          mem_re   = 1'b1;
          mem_ra   = addr_r;
          pend_nxt = 1'b1;
          pidx_nxt = addr_r;
          addr_nxt = addr_inc;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rd_data_r.valid && (rd_age >= TIME_W'(win_r))) begin
          slot_nxt      = pidx_r;
          ent_start_nxt = now_r;
          ent_cnt_nxt   = '0;
          pend_nxt      = 1'b0;
          state_nxt     = S_UPD;
        end
        if (pass_done) begin
          res_nxt   = '{limited: 1'b1, status: ST_FULL};
          state_nxt = S_DONE;
        end
      end
      S_UPD: begin
        mem_we       = 1'b1;
        mem_wa       = slot_r;
        mem_wd.valid = 1'b1;
        mem_wd.key   = key_r;
        mem_wd.start = upd_start;
        if (upd_cnt >= max_r) begin
          mem_wd.count = upd_cnt;
          res_nxt      = '{limited: 1'b1, status: ST_OVER};
        end else begin
          mem_wd.count = upd_cnt + 1'b1;
          res_nxt      = '{limited: 1'b0, status: ST_OK};
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          clr_res_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= tbl_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      win_r       <= WINDOW_RST;
      max_r       <= MAX_RST;
      addr_r      <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      pend_r      <= 1'b0;
      free_r      <= 1'b0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      max_r       <= max_nxt;
      addr_r      <= addr_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      free_r      <= free_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    now_r       <= now_nxt;
    hsh_r       <= hsh_nxt;
    kshf_r      <= kshf_nxt;
    rem_r       <= rem_nxt;
    pidx_r      <= pidx_nxt;
    free_idx_r  <= free_idx_nxt;
    slot_r      <= slot_nxt;
    ent_start_r <= ent_start_nxt;
    ent_cnt_r   <= ent_cnt_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

>>> sv/rlim_chk.sv
// ----------------------------------------------------------------------------
// rlim_chk
// Port-level checks for the rate limiter core, bound to the core module.
// ----------------------------------------------------------------------------
module rlim_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rlim_pkg::out_item_t out_data
);
  import rlim_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK) || (out_data.status == ST_OVER) ||
                  (out_data.status == ST_FULL))
    else $error("unknown status code");

  a_limited_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.limited == (out_data.status != ST_OK)))
    else $error("limited flag disagrees with status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous transaction in work");

endmodule

bind per_key_fixed_window_rate_limiter_core rlim_chk u_rlim_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/per_key_fixed_window_rate_limiter_core_tb.sv
// ----------------------------------------------------------------------------
// per_key_fixed_window_rate_limiter_core_tb
// Self-checking bench: directed and random check/clear transactions under
// several window/limit settings, each result compared with a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_key_fixed_window_rate_limiter_core_tb;
  import rlim_pkg::*;

  localparam int DEPTH        = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_PRINTS   = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  per_key_fixed_window_rate_limiter_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [15:0] win_len;
  logic [15:0] max_hits;
  bit          slot_used  [DEPTH];
  logic [31:0] slot_owner [DEPTH];
  logic [31:0] slot_begin [DEPTH];
  logic [15:0] slot_hits  [DEPTH];

  in_item_t  pending_requests[$];
  out_item_t expected_decisions[$];

  int n_queued;
  int n_results;
  int err_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_go;
  bit in_fire;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  task report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [31:0] key_hash(input logic [31:0] k);
    logic [31:0] h;
    h = HASH_SEED;
    for (int b = 3; b >= 0; b--) h = ((h << HASH_SHIFT) + h) ^ {24'd0, k[8*b +: 8]};
    return h;
  endfunction

  function automatic bit window_over(input int s, input logic [31:0] now);
    logic [31:0] gone;
    gone = now - slot_begin[s];
    return gone >= {16'd0, win_len};
  endfunction

  function automatic void claim_slot(input int s, input logic [31:0] k,
                                     input logic [31:0] now);
    slot_used[s]  = 1'b1;
    slot_owner[s] = k;
    slot_begin[s] = now;
    slot_hits[s]  = '0;
  endfunction

  function automatic int find_slot(input logic [31:0] k, input logic [31:0] now);
    int base;
    int s;
    int free_s;
    base   = int'(key_hash(k) % DEPTH);
    free_s = -1;
    for (int i = 0; i < DEPTH; i++) begin
      s = (base + i) % DEPTH;
      if (!slot_used[s]) begin
        if (free_s < 0) free_s = s;
      end else if (slot_owner[s] == k) begin
        return s;
      end
    end
    if (free_s >= 0) begin
      claim_slot(free_s, k, now);
      return free_s;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && window_over(i, now)) begin
        claim_slot(i, k, now);
        return i;
      end
    end
    return -1;
  endfunction

  function automatic out_item_t rate_decision(input in_item_t req);
    out_item_t res;
    int        s;
    res.limited = 1'b0;
    res.status  = ST_OK;
    if (req.func == FUNC_CLEAR) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      return res;
    end
    s = find_slot(req.key, req.now_time);
    if (s < 0) begin
      res.limited = 1'b1;
      res.status  = ST_FULL;
      return res;
    end
    if (window_over(s, req.now_time)) begin
      slot_begin[s] = req.now_time;
      slot_hits[s]  = '0;
    end
    if (slot_hits[s] >= max_hits) begin
      res.limited = 1'b1;
      res.status  = ST_OVER;
    end else begin
      slot_hits[s] = slot_hits[s] + 16'd1;
    end
    return res;
  endfunction

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_decisions.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        exp_res = expected_decisions.pop_front();
        if (out_data.limited !== exp_res.limited)
          report_mismatch($sformatf("result %0d: limited %b, expected %b",
                                    n_results, out_data.limited, exp_res.limited));
        if (out_data.status !== exp_res.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    n_results, out_data.status, exp_res.status));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      expected_decisions.push_back(rate_decision(in_data));
      in_fire = 1'b1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      in_fire = 1'b0;
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic add_item(input logic f, input logic [31:0] k, input logic [31:0] t);
    in_item_t it;
    it.func     = f;
    it.key      = k;
    it.now_time = t;
    pending_requests.push_back(it);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_results != n_queued) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_WINDOW) win_len = data;
    else if (idx == CFG_MAX) max_hits = data;
  endtask

  task automatic set_limits(input logic [15:0] w, input logic [15:0] m);
    write_reg(CFG_WINDOW, w);
    write_reg(CFG_MAX, m);
    write_reg(CFG_SPARE2, 16'($urandom));
    write_reg(CFG_SPARE3, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // jump_pm: per-mille of checks whose time jumps or steps backward
  task automatic run_random(input int n, input int pool_n, input int max_step,
                            input logic [31:0] t0, input int jump_pm);
    logic [31:0] pool[128];
    logic [31:0] t;
    logic [31:0] k;
    int          r;
    foreach (pool[i]) pool[i] = $urandom;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    t = t0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(999);
      if (r < 15) begin
        add_item(FUNC_CLEAR, $urandom, $urandom);
      end else begin
        r = $urandom_range(999);
        if (r < jump_pm / 2) t = $urandom;
        else if (r < jump_pm) t = t - $urandom_range(1, 100);
        else t = t + $urandom_range(0, max_step);
        r = $urandom_range(99);
        if (r < 50) k = pool[$urandom_range(7)];
        else if (r < 96) k = pool[$urandom_range(pool_n - 1)];
        else k = $urandom;
        add_item(FUNC_CHECK, k, t);
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_fire       = 1'b0;
    hold_go       = 1'b0;
    hold_left     = 0;
    n_queued      = 0;
    n_results     = 0;
    err_count     = 0;
    send_idle_pct = 8;
    recv_idle_pct = 68;
    win_len       = WINDOW_RST;
    max_hits      = MAX_RST;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits, window edge, clear
    add_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    add_item(FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(FUNC_CHECK, 32'h0000_0000, 32'd59);
    add_item(FUNC_CHECK, 32'h0000_0000, 32'd60);
    add_item(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
    wait_idle();

    // over limit, window restart, time stepping backward
    set_limits(16'd2, 16'd1);
    add_item(FUNC_CHECK, 32'h1234_5678, 32'd100);
    add_item(FUNC_CHECK, 32'h1234_5678, 32'd101);
    add_item(FUNC_CHECK, 32'h1234_5678, 32'd102);
    add_item(FUNC_CHECK, 32'h1234_5678, 32'd50);
    add_item(FUNC_CHECK, 32'h1234_5678, 32'd50);
    wait_idle();

    // zero limit
    set_limits(16'd2, 16'd0);
    add_item(FUNC_CHECK, 32'hA5A5_A5A5, 32'd7);
    add_item(FUNC_CHECK, 32'hA5A5_A5A5, 32'd7);
    wait_idle();

    // zero window
    set_limits(16'd0, 16'd2);
    repeat (3) add_item(FUNC_CHECK, 32'h5A5A_5A5A, 32'd5);
    wait_idle();

    set_limits(16'd10, 16'd3);
    run_random(300, 40, 3, $urandom, 20);
    set_limits(16'hFFFF, 16'hFFFF);
    hold_go = 1'b1;
    run_random(350, 100, 1, $urandom, 0);

    @(negedge clk);
    send_idle_pct = 68;
    recv_idle_pct = 8;
    set_limits(16'd1, 16'd1);
    run_random(300, 80, 2, 32'hFFFF_FF00, 10);
    set_limits(16'd0, 16'd2);
    run_random(200, 90, 3, $urandom, 10);
    set_limits(16'd7, 16'd0);
    run_random(150, 70, 3, $urandom, 10);

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(16'd20, 16'd5);
    run_random(350, 72, 2, $urandom, 10);
    set_limits(16'd3, 16'hFFFF);
    run_random(250, 96, 1, $urandom, 10);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_decisions.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_decisions.size()));
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
